/* sv/vxe_pkg.sv */
// ----------------------------------------------------------------------------
// Voxel erosion package
// Opcodes, status codes, controller states and the command and status bundles
// shared by the controller and the datapath.
// ----------------------------------------------------------------------------
package vxe_pkg;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 8;
  localparam int unsigned DIM_CFG_W  = 5;
  localparam int unsigned MINN_W     = 3;
  localparam int unsigned PASS_W     = 8;
  localparam int unsigned TOTAL_W    = 13;
  localparam int unsigned TOTAL_MAX  = 8191;
  localparam int unsigned STEP_W     = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_BOX_X     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BOX_Y     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BOX_Z     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_NB    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PASS_LIM  = 3'd4;

  // Neighbor visit order within one mark step sequence.
  localparam logic [STEP_W-1:0] NB_SELF = 3'd0;
  localparam logic [STEP_W-1:0] NB_XP   = 3'd1;
  localparam logic [STEP_W-1:0] NB_XM   = 3'd2;
  localparam logic [STEP_W-1:0] NB_ZP   = 3'd3;
  localparam logic [STEP_W-1:0] NB_ZM   = 3'd4;
  localparam logic [STEP_W-1:0] NB_YP   = 3'd5;
  localparam logic [STEP_W-1:0] NB_YM   = 3'd6;
  localparam logic [STEP_W-1:0] NB_DONE = 3'd7;

  localparam logic [1:0] SETTLE_CYCLES = 2'd2;

  typedef enum logic [1:0] {
    OP_LOAD = 2'd0,
    OP_RUN  = 2'd1,
    OP_READ = 2'd2,
    OP_NOP  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_PAST_END   = 2'd1,
    ST_NOT_LOADED = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD_WAIT,
    S_RUN_START,
    S_MARK,
    S_CLEAR,
    S_PASS_END
  } state_e;

  typedef struct packed {
    logic              load_wr;
    logic              rd_issue;
    logic              out_imm;
    status_e           out_status;
    logic              out_rd;
    logic              run_init;
    logic              run_done;
    logic              scan_rst;
    logic              scan_adv;
    logic [STEP_W-1:0] step;
    logic              mark_rd;
    logic              mark_acc;
    logic              mark_wr;
    logic              clr_rd;
    logic              clr_wr;
    logic              pass_end;
  } cmd_t;

  typedef struct packed {
    logic load_full;
    logic read_end;
    logic out_free;
    logic interior;
    logic scan_last;
    logic limit_zero;
    logic pass_last;
    logic cleared_zero;
  } sts_t;

endpackage

/* sv/vxe_if.sv */
// ----------------------------------------------------------------------------
// Voxel erosion channels
// Valid/ready channels for command beats in and result beats out.
// ----------------------------------------------------------------------------
interface vxe_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] op;
  logic       solid_in;

  modport source (output valid, output op, output solid_in, input ready);
  modport sink   (input valid, input op, input solid_in, output ready);
endinterface

interface vxe_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic        solid_out;
  logic        removed_out;
  logic [7:0]  passes_run;
  logic [12:0] removed_total;

  modport source (output valid, output status, output solid_out, output removed_out,
                  output passes_run, output removed_total, input ready);
  modport sink   (input valid, input status, input solid_out, input removed_out,
                  input passes_run, input removed_total, output ready);
endinterface

/* sv/voxel_erosion_by_neighbour_count.sv */
// ----------------------------------------------------------------------------
// Voxel erosion by neighbor count
// Loads a voxel box, erodes its interior by six-neighbor count, reads it back.
//
//   channel   dir  beat fields
//   in_i      in   op, solid_in
//   out_o     out  status, solid_out, removed_out, passes_run, removed_total
//   cfg_*     in   index, write data (write only)
//
// Load, unused opcode and refused items are answered from the idle state; a read
// passes through the registered occupancy memory port and a wait state.
// A run sweeps the box once per pass to mark interior voxels, reading each one
// and its six neighbors, then once more to clear the marked ones, paced by the
// single read port of the occupancy memory.
// After reset or a register write, items wait for the box volume to settle.
// A result waits in an output register; input also stalls while it is held.
// Memories are not cleared by reset.
// ----------------------------------------------------------------------------
module voxel_erosion_by_neighbour_count import vxe_pkg::*; #(
  parameter int unsigned MAX_DIM = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  vxe_in_if.sink                in_i,
  vxe_out_if.source             out_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  cmd_t cmd;
  sts_t sts;

  vxe_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_op_i    (op_e'(in_i.op)),
    .in_ready_o (in_i.ready),
    .cfg_we_i   (cfg_we_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  vxe_dpath #(
    .MAX_DIM (MAX_DIM)
  ) u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_solid_i    (in_i.solid_in),
    .out_ready_i   (out_o.ready),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .out_valid_o   (out_o.valid),
    .out_status_o  (out_o.status),
    .out_solid_o   (out_o.solid_out),
    .out_removed_o (out_o.removed_out),
    .out_passes_o  (out_o.passes_run),
    .out_total_o   (out_o.removed_total)
  );

endmodule

/* sv/vxe_ctrl.sv */
// ----------------------------------------------------------------------------
// Voxel erosion controller
// Sequences load, read and run beats, and walks the mark and clear sweeps.
// ----------------------------------------------------------------------------
module vxe_ctrl import vxe_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  op_e  in_op_i,
  output logic in_ready_o,
  input  logic cfg_we_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e            state_q, state_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [1:0]        settle_q, settle_d;
  logic              accept;

  assign in_ready_o = (state_q == S_IDLE) && (settle_q == 2'd0) && sts_i.out_free;
  assign accept     = in_valid_i && in_ready_o;

  // The volume is a two-stage product of the sizes, so items wait after a write.
  always_comb begin
    if (cfg_we_i) begin
      settle_d = SETTLE_CYCLES;
    end else if (settle_q != 2'd0) begin
      settle_d = settle_q - 2'd1;
    end else begin
      settle_d = settle_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      step_q   <= NB_SELF;
      settle_q <= SETTLE_CYCLES;
    end else begin
      state_q  <= state_d;
      step_q   <= step_d;
      settle_q <= settle_d;
    end
  end

  always_comb begin
    state_d            = state_q;
    step_d             = step_q;
    cmd_o              = '0;
    cmd_o.out_status   = ST_OK;
    cmd_o.step         = step_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          unique case (in_op_i)
            OP_LOAD: begin
              cmd_o.out_imm = 1'b1;
              if (sts_i.load_full) begin
                cmd_o.out_status = ST_PAST_END;
              end else begin
                cmd_o.load_wr = 1'b1;
              end
            end
            OP_RUN: begin
              if (!sts_i.load_full) begin
                cmd_o.out_imm    = 1'b1;
                cmd_o.out_status = ST_NOT_LOADED;
              end else begin
                cmd_o.run_init = 1'b1;
                state_d        = S_RUN_START;
              end
            end
            OP_READ: begin
              if (sts_i.read_end) begin
                cmd_o.out_imm    = 1'b1;
                cmd_o.out_status = ST_PAST_END;
              end else begin
                cmd_o.rd_issue = 1'b1;
                state_d        = S_RD_WAIT;
              end
            end
            OP_NOP: begin
              cmd_o.out_imm = 1'b1;
            end
          endcase
        end
      end
      S_RD_WAIT: begin
        cmd_o.out_rd = 1'b1;
        state_d      = S_IDLE;
      end
      S_RUN_START: begin
        if (sts_i.limit_zero) begin
          cmd_o.run_done = 1'b1;
          cmd_o.out_imm  = 1'b1;
          state_d        = S_IDLE;
        end else begin
          cmd_o.scan_rst = 1'b1;
          step_d         = NB_SELF;
          state_d        = S_MARK;
        end
      end
      S_MARK: begin
        if (sts_i.interior && (step_q != NB_DONE)) begin
          cmd_o.mark_rd  = 1'b1;
          cmd_o.mark_acc = (step_q != NB_SELF);
          step_d         = step_q + 3'd1;
        end else begin
          cmd_o.mark_acc = sts_i.interior;
          cmd_o.mark_wr  = sts_i.interior;
          step_d         = NB_SELF;
          if (sts_i.scan_last) begin
            cmd_o.scan_rst = 1'b1;
            state_d        = S_CLEAR;
          end else begin
            cmd_o.scan_adv = 1'b1;
          end
        end
      end
      S_CLEAR: begin
        if (sts_i.interior && (step_q == NB_SELF)) begin
          cmd_o.clr_rd = 1'b1;
          step_d       = NB_XP;
        end else begin
          cmd_o.clr_wr = sts_i.interior;
          step_d       = NB_SELF;
          if (sts_i.scan_last) begin
            state_d = S_PASS_END;
          end else begin
            cmd_o.scan_adv = 1'b1;
          end
        end
      end
      S_PASS_END: begin
        cmd_o.pass_end = 1'b1;
        if (sts_i.cleared_zero || sts_i.pass_last) begin
          cmd_o.run_done = 1'b1;
          cmd_o.out_imm  = 1'b1;
          state_d        = S_IDLE;
        end else begin
          cmd_o.scan_rst = 1'b1;
          state_d        = S_MARK;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

/* sv/vxe_dpath.sv */
// ----------------------------------------------------------------------------
// Voxel erosion datapath
// Configuration registers, occupancy and mark memories, scan position,
// neighbor counting, pass counters and the result register.
// ----------------------------------------------------------------------------
module vxe_dpath import vxe_pkg::*; #(
  parameter int unsigned MAX_DIM = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  in_solid_i,
  input  logic                  out_ready_i,
  input  cmd_t                  cmd_i,
  output sts_t                  sts_o,
  output logic                  out_valid_o,
  output logic [1:0]            out_status_o,
  output logic                  out_solid_o,
  output logic                  out_removed_o,
  output logic [PASS_W-1:0]     out_passes_o,
  output logic [TOTAL_W-1:0]    out_total_o
);

  localparam int unsigned DIM_W  = $clog2(MAX_DIM + 1);
  localparam int unsigned VOX    = MAX_DIM * MAX_DIM * MAX_DIM;
  localparam int unsigned ADDR_W = $clog2(VOX);
  localparam int unsigned PTR_W  = ADDR_W + 1;
  localparam int unsigned SUM_W  = ((TOTAL_W > PTR_W) ? TOTAL_W : PTR_W) + 1;

  logic [DIM_CFG_W-1:0] box_x_q, box_y_q, box_z_q;
  logic [MINN_W-1:0]    min_nb_q;
  logic [PASS_W-1:0]    pass_lim_q;

  logic [DIM_W-1:0] nx, ny, nz;
  logic [PTR_W-1:0] plane_q, vol_q;

  logic [PTR_W-1:0]  load_ptr_q, read_ptr_q, cleared_q;
  logic [PASS_W-1:0] pass_cnt_q;
  logic [TOTAL_W-1:0] removed_q;
  logic [SUM_W-1:0]  removed_sum;

  logic [DIM_W-1:0]  x_q, y_q, z_q;
  logic [ADDR_W-1:0] i_q, nb_addr;

  logic orig_mem [0:VOX-1];
  logic cur_mem  [0:VOX-1];
  logic mark_mem [0:VOX-1];
  logic orig_rd_q, cur_rd_q, mark_rd_q;

  logic              center_q;
  logic [2:0]        nb_cnt_q;
  logic              mark_bit;
  logic              cur_we, cur_wdata;
  logic [ADDR_W-1:0] cur_waddr, cur_raddr;

  logic          out_valid_q, out_solid_q, out_removed_q;
  logic [1:0]    out_status_q;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_CFG_W-1:0] v);
    if (v < 5'd3) begin
      return DIM_W'(3);
    end else if (32'(v) > MAX_DIM) begin
      return DIM_W'(MAX_DIM);
    end else begin
      return DIM_W'(v);
    end
  endfunction

  assign nx = clamp_dim(box_x_q);
  assign ny = clamp_dim(box_y_q);
  assign nz = clamp_dim(box_z_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      box_x_q    <= 5'd16;
      box_y_q    <= 5'd16;
      box_z_q    <= 5'd16;
      min_nb_q   <= 3'd0;
      pass_lim_q <= 8'd1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_BOX_X:    box_x_q    <= cfg_wdata_i[DIM_CFG_W-1:0];
        CFG_BOX_Y:    box_y_q    <= cfg_wdata_i[DIM_CFG_W-1:0];
        CFG_BOX_Z:    box_z_q    <= cfg_wdata_i[DIM_CFG_W-1:0];
        CFG_MIN_NB:   min_nb_q   <= cfg_wdata_i[MINN_W-1:0];
        CFG_PASS_LIM: pass_lim_q <= cfg_wdata_i[PASS_W-1:0];
        default: ;
      endcase
    end
  end

  // Plane and volume recomputed every cycle, one multiplication per stage.
  always_ff @(posedge clk_i) begin
    plane_q <= PTR_W'(nx) * PTR_W'(nz);
    vol_q   <= plane_q * PTR_W'(ny);
  end

  // Scan position over the whole box, x fastest, then z, then y.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q <= '0;
      y_q <= '0;
      z_q <= '0;
      i_q <= '0;
    end else if (cmd_i.scan_rst) begin
      x_q <= '0;
      y_q <= '0;
      z_q <= '0;
      i_q <= '0;
    end else if (cmd_i.scan_adv) begin
      i_q <= i_q + ADDR_W'(1);
      if (x_q == nx - DIM_W'(1)) begin
        x_q <= '0;
        if (z_q == nz - DIM_W'(1)) begin
          z_q <= '0;
          y_q <= y_q + DIM_W'(1);
        end else begin
          z_q <= z_q + DIM_W'(1);
        end
      end else begin
        x_q <= x_q + DIM_W'(1);
      end
    end
  end

  always_comb begin
    case (cmd_i.step)
      NB_XP:   nb_addr = i_q + ADDR_W'(1);
      NB_XM:   nb_addr = i_q - ADDR_W'(1);
      NB_ZP:   nb_addr = i_q + ADDR_W'(nx);
      NB_ZM:   nb_addr = i_q - ADDR_W'(nx);
      NB_YP:   nb_addr = i_q + plane_q[ADDR_W-1:0];
      NB_YM:   nb_addr = i_q - plane_q[ADDR_W-1:0];
      default: nb_addr = i_q;
    endcase
  end

  assign cur_we    = cmd_i.load_wr || (cmd_i.clr_wr && mark_rd_q);
  assign cur_waddr = cmd_i.load_wr ? load_ptr_q[ADDR_W-1:0] : i_q;
  assign cur_wdata = cmd_i.load_wr && in_solid_i;
  assign cur_raddr = cmd_i.mark_rd ? nb_addr : read_ptr_q[ADDR_W-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_wr) begin
      orig_mem[load_ptr_q[ADDR_W-1:0]] <= in_solid_i;
    end
    if (cmd_i.rd_issue) begin
      orig_rd_q <= orig_mem[read_ptr_q[ADDR_W-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cur_we) begin
      cur_mem[cur_waddr] <= cur_wdata;
    end
    if (cmd_i.mark_rd || cmd_i.rd_issue) begin
      cur_rd_q <= cur_mem[cur_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mark_wr) begin
      mark_mem[i_q] <= mark_bit;
    end
    if (cmd_i.clr_rd) begin
      mark_rd_q <= mark_mem[i_q];
    end
  end

  // The first word back is the voxel itself, the six after it its neighbors.
  assign mark_bit = center_q &&
                    (({1'b0, nb_cnt_q} + {3'b000, cur_rd_q}) < {1'b0, min_nb_q});

  always_ff @(posedge clk_i) begin
    if (cmd_i.mark_acc) begin
      if (cmd_i.step == NB_XP) begin
        center_q <= cur_rd_q;
        nb_cnt_q <= 3'd0;
      end else begin
        nb_cnt_q <= nb_cnt_q + {2'b00, cur_rd_q};
      end
    end
  end

  assign removed_sum = SUM_W'(removed_q) + SUM_W'(cleared_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      load_ptr_q <= '0;
      read_ptr_q <= '0;
      cleared_q  <= '0;
      pass_cnt_q <= '0;
      removed_q  <= '0;
    end else begin
      if (cmd_i.load_wr) begin
        load_ptr_q <= load_ptr_q + PTR_W'(1);
      end
      if (cmd_i.rd_issue) begin
        read_ptr_q <= read_ptr_q + PTR_W'(1);
      end else if (cmd_i.run_done) begin
        read_ptr_q <= '0;
      end
      if (cmd_i.run_init) begin
        cleared_q  <= '0;
        pass_cnt_q <= '0;
        removed_q  <= '0;
      end else if (cmd_i.pass_end) begin
        cleared_q  <= '0;
        pass_cnt_q <= pass_cnt_q + 8'd1;
        if (removed_sum > SUM_W'(TOTAL_MAX)) begin
          removed_q <= TOTAL_W'(TOTAL_MAX);
        end else begin
          removed_q <= removed_sum[TOTAL_W-1:0];
        end
      end else if (cmd_i.clr_wr && mark_rd_q) begin
        cleared_q <= cleared_q + PTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_imm || cmd_i.out_rd) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_imm) begin
      out_status_q  <= cmd_i.out_status;
      out_solid_q   <= 1'b0;
      out_removed_q <= 1'b0;
    end else if (cmd_i.out_rd) begin
      out_status_q  <= ST_OK;
      out_solid_q   <= cur_rd_q;
      out_removed_q <= orig_rd_q && !cur_rd_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_status_o  = out_status_q;
  assign out_solid_o   = out_solid_q;
  assign out_removed_o = out_removed_q;
  assign out_passes_o  = pass_cnt_q;
  assign out_total_o   = removed_q;

  assign sts_o.load_full    = (load_ptr_q >= vol_q);
  assign sts_o.read_end     = (read_ptr_q >= vol_q);
  assign sts_o.out_free     = !out_valid_q || out_ready_i;
  assign sts_o.interior     = (x_q != '0) && (x_q != nx - DIM_W'(1)) &&
                              (y_q != '0) && (y_q != ny - DIM_W'(1)) &&
                              (z_q != '0) && (z_q != nz - DIM_W'(1));
  assign sts_o.scan_last    = (x_q == nx - DIM_W'(1)) && (y_q == ny - DIM_W'(1)) &&
                              (z_q == nz - DIM_W'(1));
  assign sts_o.limit_zero   = (pass_lim_q == 8'd0);
  assign sts_o.pass_last    = (({1'b0, pass_cnt_q} + 9'd1) == {1'b0, pass_lim_q});
  assign sts_o.cleared_zero = (cleared_q == '0);

`ifndef SYNTHESIS
  a_load_in_box: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_wr |-> (load_ptr_q < vol_q))
    else $error("load written beyond the box");

  a_out_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.out_imm || cmd_i.out_rd) |-> (!out_valid_q || out_ready_i))
    else $error("result register overwritten while waiting");

  a_mark_interior: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.mark_wr || cmd_i.clr_rd) |-> sts_o.interior)
    else $error("mark access outside the box interior");

  a_pass_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.pass_end |-> (pass_cnt_q < pass_lim_q))
    else $error("pass count beyond the pass limit");
`endif

endmodule
